### hdl/tsrc_pkg.sv
// Constants and types shared by the TCP segment receive checker.
package tsrc_pkg;

   localparam int MAX_SEGMENT_BYTES = 65535;

   localparam logic [15:0] IP_PROTO_TCP = 16'd6;

   // Byte offsets within the TCP header
   localparam logic [15:0] OFS_SPORT = 16'd0;
   localparam logic [15:0] OFS_DPORT = 16'd2;
   localparam logic [15:0] OFS_SEQ   = 16'd4;
   localparam logic [15:0] OFS_ACK   = 16'd8;
   localparam logic [15:0] OFS_DOFF  = 16'd12;
   localparam logic [15:0] OFS_FLAGS = 16'd13;
   localparam logic [15:0] OFS_WIN   = 16'd14;
   localparam logic [15:0] OFS_CSUM  = 16'd16;
   localparam logic [15:0] OFS_OPT   = 16'd20;

   // Option kinds
   localparam logic [7:0] OPT_END = 8'd0;
   localparam logic [7:0] OPT_NOP = 8'd1;
   localparam logic [7:0] OPT_MSS = 8'd2;

   // Option parser phases
   localparam logic [1:0] PH_KIND = 2'd0;
   localparam logic [1:0] PH_LEN  = 2'd1;
   localparam logic [1:0] PH_SKIP = 2'd2;

   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 184;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        last_byte;
      logic [18:0] addr_sum;
   } in_word_type;

endpackage

### hdl/tcp_segment_rx_checker.sv
// TCP segment receive checker: header parse, option parse and checksum check.
//
// Usage:
//   req_ channel: one segment byte per word, wire order. req_tlast marks the
//   final byte. The IPv4 addresses ride along in req_tdata and are taken from
//   the final byte's word.
//   rsp_ channel: one word per segment, issued for the final byte, holding the
//   parsed header fields, MSS option data, segment length and checksum verdict.
//   Final bytes pass the input register, then the result register, to rsp_.
//   Throughput: one byte per cycle while no final byte is held, set by the
//   single input register and the combinational ones' complement adder/parser.
//   Stall: a pending byte that is not a final byte keeps moving while a result
//   waits on rsp_tready; a final byte waits in the input register until the
//   result register is free, and req_tready drops while it waits.
//   Reset: clears the byte count, running sum, parser state and both valid
//   flags; req_tready is high out of reset.
module tcp_segment_rx_checker
   import tsrc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // data_byte[7:0], src_addr[39:8], dst_addr[71:40]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // checksum_ok[0], computed_checksum[16:1], max_seg_size[32:17],
   // option_count[36:33], src_port[52:37], dst_port[68:53],
   // seq_num[100:69], ack_num[132:101], tcp_flags[140:133],
   // window_field[156:141], header_words[160:157], segment_length[176:161]
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic              a_vld_ff;
   in_word_type       a_word_ff;
   in_word_type       a_word_in;
   logic              b_go;
   logic              seg_end;

   logic              rsp_vld_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [RSP_DATA_W-1:0] rsp_data_in;

   logic [15:0] byte_index_ff, byte_index_in;
   logic [15:0] sum_acc_ff,    sum_acc_in;
   logic [7:0]  hold_ff,       hold_in;
   logic [31:0] seq_ff,        seq_in;
   logic [31:0] ack_ff,        ack_in;
   logic [15:0] sport_ff,      sport_in;
   logic [15:0] dport_ff,      dport_in;
   logic [15:0] window_ff,     window_in;
   logic [15:0] rx_csum_ff,    rx_csum_in;
   logic [3:0]  offset_ff,     offset_in;
   logic [7:0]  flags_ff,      flags_in;
   logic [1:0]  opt_phase_ff,  opt_phase_in;
   logic [7:0]  opt_rem_ff,    opt_rem_in;
   logic [15:0] mss_ff,        mss_in;
   logic [3:0]  mss_cnt_ff,    mss_cnt_in;
   logic        opt_ended_ff,  opt_ended_in;
   logic [1:0]  mss_cap_ff,    mss_cap_in;
   logic        too_long_ff,   too_long_in;

   logic [7:0]  b;
   logic [15:0] idx;
   logic        take;
   logic [7:0]  v;
   logic [15:0] word_add;
   logic [16:0] part_sum;
   logic [5:0]  hdr_end;
   logic        past_end;
   logic [15:0] pad_word;
   logic [20:0] total;
   logic [16:0] fold1;
   logic [15:0] fold2;
   logic [15:0] csum;
   logic        csum_ok;

   // input register
   assign a_word_in.data_byte = req_tdata[7:0];
   assign a_word_in.last_byte = req_tlast;
   assign a_word_in.addr_sum  = 19'({3'b000, req_tdata[39:24]}) + 19'({3'b000, req_tdata[23:8]})
                              + 19'({3'b000, req_tdata[71:56]}) + 19'({3'b000, req_tdata[55:40]})
                              + 19'({3'b000, IP_PROTO_TCP});

   assign b_go       = a_vld_ff && (!a_word_ff.last_byte || !rsp_vld_ff || rsp_tready);
   assign seg_end    = b_go && a_word_ff.last_byte;
   assign req_tready = !a_vld_ff || b_go;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (req_tready) begin
         a_vld_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         a_word_ff <= a_word_in;
      end
   end

   // byte processing
   assign b        = a_word_ff.data_byte;
   assign idx      = byte_index_ff;
   assign take     = byte_index_ff != 16'(MAX_SEGMENT_BYTES);
   assign hdr_end  = {offset_ff, 2'b00};
   assign past_end = idx >= {10'd0, hdr_end};
   assign v        = (idx == OFS_CSUM || idx == OFS_CSUM + 16'd1) ? 8'd0 : b;
   assign part_sum = {1'b0, sum_acc_ff} + {1'b0, hold_ff, v};

   always_comb begin
      byte_index_in = byte_index_ff;
      sum_acc_in    = sum_acc_ff;
      hold_in       = hold_ff;
      seq_in        = seq_ff;
      ack_in        = ack_ff;
      sport_in      = sport_ff;
      dport_in      = dport_ff;
      window_in     = window_ff;
      rx_csum_in    = rx_csum_ff;
      offset_in     = offset_ff;
      flags_in      = flags_ff;
      opt_phase_in  = opt_phase_ff;
      opt_rem_in    = opt_rem_ff;
      mss_in        = mss_ff;
      mss_cnt_in    = mss_cnt_ff;
      opt_ended_in  = opt_ended_ff;
      mss_cap_in    = mss_cap_ff;
      too_long_in   = too_long_ff;
      word_add      = 16'd0;

      if (!take) begin
         too_long_in = 1'b1;
      end else begin
         byte_index_in = idx + 16'd1;

         case (idx)
            OFS_SPORT:         sport_in[15:8]   = b;
            OFS_SPORT + 16'd1: sport_in[7:0]    = b;
            OFS_DPORT:         dport_in[15:8]   = b;
            OFS_DPORT + 16'd1: dport_in[7:0]    = b;
            OFS_DOFF:          offset_in        = b[7:4];
            OFS_FLAGS:         flags_in         = b;
            OFS_WIN:           window_in[15:8]  = b;
            OFS_WIN + 16'd1:   window_in[7:0]   = b;
            OFS_CSUM:          rx_csum_in[15:8] = b;
            OFS_CSUM + 16'd1:  rx_csum_in[7:0]  = b;
            default: begin
               if (idx >= OFS_SEQ && idx < OFS_ACK) begin
                  seq_in = {seq_ff[23:0], b};
               end else if (idx >= OFS_ACK && idx < OFS_DOFF) begin
                  ack_in = {ack_ff[23:0], b};
               end
            end
         endcase

         if (!idx[0]) begin
            hold_in = v;
         end else begin
            word_add   = {hold_ff, v};
            sum_acc_in = part_sum[15:0] + {15'd0, part_sum[16]};
         end

         if (mss_cap_ff != 2'd0) begin
            if (mss_cap_ff <= 2'd2) begin
               mss_in = {mss_ff[7:0], b};
            end
            mss_cap_in = mss_cap_ff - 2'd1;
         end

         if (!opt_ended_ff && idx >= OFS_OPT) begin
            case (opt_phase_ff)
               PH_SKIP: begin
                  if (opt_rem_ff > 8'd0) begin
                     opt_rem_in = opt_rem_ff - 8'd1;
                  end
                  if (opt_rem_ff <= 8'd1) begin
                     opt_phase_in = PH_KIND;
                  end
               end
               PH_LEN: begin
                  if (b <= OPT_NOP) begin
                     if (b == OPT_END || past_end) begin
                        opt_ended_in = 1'b1;
                     end
                     opt_phase_in = PH_KIND;
                  end else begin
                     opt_rem_in   = b - 8'd2;
                     opt_phase_in = (b == 8'd2) ? PH_KIND : PH_SKIP;
                  end
               end
               default: begin
                  if (past_end || b == OPT_END) begin
                     opt_ended_in = 1'b1;
                  end else if (b != OPT_NOP) begin
                     if (b == OPT_MSS) begin
                        if (mss_cnt_ff != 4'hf) begin
                           mss_cnt_in = mss_cnt_ff + 4'd1;
                        end
                        mss_cap_in = 2'd3;
                     end
                     opt_phase_in = PH_LEN;
                  end
               end
            endcase
         end
      end
   end

   // closing sum: running sum, this byte's word, odd pad, pseudo-header
   assign pad_word = byte_index_in[0] ? {hold_in, 8'h00} : 16'd0;
   assign total    = 21'(sum_acc_ff) + 21'(word_add) + 21'(pad_word)
                   + 21'(a_word_ff.addr_sum) + 21'(byte_index_in);
   assign fold1    = {1'b0, total[15:0]} + {12'd0, total[20:16]};
   assign fold2    = fold1[15:0] + {15'd0, fold1[16]};
   assign csum     = ~fold2;
   assign csum_ok  = !too_long_in && (csum == rx_csum_in);

   assign rsp_data_in = {7'd0, byte_index_in, offset_in, window_in, flags_in, ack_in, seq_in,
                         dport_in, sport_in, mss_cnt_in, mss_in, csum, csum_ok};

   always_ff @(posedge clock) begin
      if (reset || seg_end) begin
         byte_index_ff <= 16'd0;
         sum_acc_ff    <= 16'd0;
         hold_ff       <= 8'd0;
         seq_ff        <= 32'd0;
         ack_ff        <= 32'd0;
         sport_ff      <= 16'd0;
         dport_ff      <= 16'd0;
         window_ff     <= 16'd0;
         rx_csum_ff    <= 16'd0;
         offset_ff     <= 4'd0;
         flags_ff      <= 8'd0;
         opt_phase_ff  <= PH_KIND;
         opt_rem_ff    <= 8'd0;
         mss_ff        <= 16'd0;
         mss_cnt_ff    <= 4'd0;
         opt_ended_ff  <= 1'b0;
         mss_cap_ff    <= 2'd0;
         too_long_ff   <= 1'b0;
      end else if (b_go) begin
         byte_index_ff <= byte_index_in;
         sum_acc_ff    <= sum_acc_in;
         hold_ff       <= hold_in;
         seq_ff        <= seq_in;
         ack_ff        <= ack_in;
         sport_ff      <= sport_in;
         dport_ff      <= dport_in;
         window_ff     <= window_in;
         rx_csum_ff    <= rx_csum_in;
         offset_ff     <= offset_in;
         flags_ff      <= flags_in;
         opt_phase_ff  <= opt_phase_in;
         opt_rem_ff    <= opt_rem_in;
         mss_ff        <= mss_in;
         mss_cnt_ff    <= mss_cnt_in;
         opt_ended_ff  <= opt_ended_in;
         mss_cap_ff    <= mss_cap_in;
         too_long_ff   <= too_long_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (seg_end) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_ff <= 1'b0;
      end
      if (seg_end) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
